/* rtl/rcv3_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcv3_pkg: shared types and constants of the RGB 3x3 convolution core
// Holds the configuration register codes, arithmetic widths and the
// control bundle that steers the per-channel filter lanes.
// ----------------------------------------------------------------------------
package rcv3_pkg;

    // Default line length the line buffers are sized for.
    localparam int MAX_WIDTH_DFLT = 1024;

    // Frame height limit and the row counter that covers it.
    localparam int HEIGHT_MAX = 1024;
    localparam int ROW_W      = 10;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int DIM_W      = 11;

    // Pixel and coefficient formats.
    localparam int PIX_W    = 8;
    localparam int COEF_W   = 16;
    localparam int FRAC_W   = 14;
    localparam int TAPS     = 9;
    localparam int RGB_W    = 3 * PIX_W;

    // Configuration register codes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH    = 3'd0,
        REG_HEIGHT   = 3'd1,
        REG_COEF_TOP = 3'd2,
        REG_COEF_MID = 3'd3,
        REG_COEF_BOT = 3'd4
    } t_cfg_reg;

    // Nine Q2.14 taps, tap (row * 3 + column) at index row * 3 + column.
    typedef logic [TAPS-1:0][COEF_W-1:0] t_kernel;

    // Arithmetic widths: 9-bit signed pixel times 16-bit coefficient,
    // then a sum of three and a sum of nine.
    typedef logic signed [PIX_W+COEF_W:0]   t_prod;
    typedef logic signed [PIX_W+COEF_W+2:0] t_rsum;
    typedef logic signed [PIX_W+COEF_W+4:0] t_acc;

    // Stage enables handed to every lane.
    typedef struct packed {
        logic shift;     // shift the window and register the products
        logic sum_rows;  // register the three row sums
        logic sum_all;   // register the saturated result
    } t_lane_ctl;

endpackage
`default_nettype wire

/* rtl/rgb_conv2d_valid_3x3_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Registers from window-completing pixel to result: input, products, row sums, result, output.
// Throughput: one pixel per cycle unless the output stalls; per-stage valids squeeze bubbles.
// One line-buffer read and one write per memory per cycle set the pixel rate.
// Reset (synchronous, active low) clears counters, window and pipeline valids,
// and loads width min(MAX_WIDTH,1024), height 1024, zero coefficients; line RAMs are not cleared.
// ----------------------------------------------------------------------------
// rgb_conv2d_valid_3x3_core: streaming 3x3 convolution over RGB pixels
// Raster counters and line buffers build a window per channel; three
// lanes filter the channels in parallel and an output register merges them.
// ----------------------------------------------------------------------------
module rgb_conv2d_valid_3x3_core #(
    parameter int MAX_WIDTH = rcv3_pkg::MAX_WIDTH_DFLT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rcv3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [rcv3_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Pixel input stream
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [rcv3_pkg::RGB_W-1:0]        i_s_axis_tdata,  // in_red, in_green, in_blue
    // Filtered output stream
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic      [rcv3_pkg::RGB_W-1:0]        o_m_axis_tdata,  // out_red, out_green, out_blue
    output logic                                   o_m_axis_tlast
);

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int RW        = rcv3_pkg::ROW_W;
    localparam int PW        = rcv3_pkg::PIX_W;
    localparam int WIDTH_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

    // Configuration registers (dimensions kept as last index).
    logic [CW-1:0]                    r_w_last;
    logic [RW-1:0]                    r_h_last;
    logic [rcv3_pkg::CFG_DATA_W-1:0]  r_coef_top;
    logic [rcv3_pkg::CFG_DATA_W-1:0]  r_coef_mid;
    logic [rcv3_pkg::CFG_DATA_W-1:0]  r_coef_bot;
    logic [CW-1:0]                    n_w_last;
    logic [RW-1:0]                    n_h_last;
    logic [rcv3_pkg::DIM_W-1:0]       cfg_dim;
    rcv3_pkg::t_kernel                kernel;

    // Raster position.
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    // Pipeline control.
    logic en1, en2, en3, en4, out_free, s_acc;
    logic emit, frame_last;
    logic r_v1, r_v2, r_v3, r_v4;
    logic r_s1_emit, r_s1_last, r_s2_last, r_s3_last, r_s4_last;
    logic [CW-1:0]              r_s1_idx;
    logic [rcv3_pkg::RGB_W-1:0] r_s1_pix;
    logic [rcv3_pkg::RGB_W-1:0] rd_top, rd_mid;
    rcv3_pkg::t_lane_ctl        lane_ctl;
    logic [2:0][PW-1:0]         lane_res;

    // Output register.
    logic                       r_out_valid;
    logic                       r_out_last;
    logic [rcv3_pkg::RGB_W-1:0] r_out_data;

    // Clamp the written dimension into the supported range.
    assign cfg_dim = i_cfg_data[rcv3_pkg::DIM_W-1:0];

    always_comb begin
        if (cfg_dim < rcv3_pkg::DIM_W'(3)) begin
            n_w_last = CW'(2);
        end else if (int'(cfg_dim) > MAX_WIDTH) begin
            n_w_last = CW'(MAX_WIDTH - 1);
        end else begin
            n_w_last = CW'(cfg_dim - rcv3_pkg::DIM_W'(1));
        end
        if (cfg_dim < rcv3_pkg::DIM_W'(3)) begin
            n_h_last = RW'(2);
        end else if (cfg_dim > rcv3_pkg::DIM_W'(rcv3_pkg::HEIGHT_MAX)) begin
            n_h_last = RW'(rcv3_pkg::HEIGHT_MAX - 1);
        end else begin
            n_h_last = RW'(cfg_dim - rcv3_pkg::DIM_W'(1));
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last   <= CW'(WIDTH_RST - 1);
            r_h_last   <= RW'(rcv3_pkg::HEIGHT_MAX - 1);
            r_coef_top <= '0;
            r_coef_mid <= '0;
            r_coef_bot <= '0;
        end else if (i_cfg_valid) begin
            case (rcv3_pkg::t_cfg_reg'(i_cfg_index))
                rcv3_pkg::REG_WIDTH:    r_w_last   <= n_w_last;
                rcv3_pkg::REG_HEIGHT:   r_h_last   <= n_h_last;
                rcv3_pkg::REG_COEF_TOP: r_coef_top <= i_cfg_data;
                rcv3_pkg::REG_COEF_MID: r_coef_mid <= i_cfg_data;
                rcv3_pkg::REG_COEF_BOT: r_coef_bot <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign kernel = {r_coef_bot, r_coef_mid, r_coef_top};

    // Stage enables: a stage loads when it is empty or its content moves on.
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign en4      = !r_v4 || out_free;
    assign en3      = !r_v3 || en4;
    assign en2      = !r_v2 || en3;
    assign en1      = !r_v1 || en2;
    assign s_acc    = i_s_axis_tvalid && en1;

    assign o_s_axis_tready = en1;

    // Output decision for the pixel at the current position.
    assign emit = (r_col >= CW'(2)) && (r_row >= RW'(2))
               && (r_col <= r_w_last) && (r_row <= r_h_last);
    assign frame_last = (r_col == r_w_last) && (r_row == r_h_last);

    // Raster counters advance on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (s_acc) begin
            if (r_col >= r_w_last) begin
                r_col <= '0;
                r_row <= (r_row >= r_h_last) ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= s_acc;
            if (en2) r_v2 <= r_v1 && r_s1_emit;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_idx  <= r_col;
            r_s1_pix  <= i_s_axis_tdata;
            r_s1_emit <= emit;
            r_s1_last <= frame_last;
        end
        if (lane_ctl.shift)    r_s2_last <= r_s1_last;
        if (lane_ctl.sum_rows) r_s3_last <= r_s2_last;
        if (lane_ctl.sum_all)  r_s4_last <= r_s3_last;
    end

    assign lane_ctl.shift    = en2 && r_v1;
    assign lane_ctl.sum_rows = en3 && r_v2;
    assign lane_ctl.sum_all  = en4 && r_v3;

    rcv3_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk      (i_clk),
        .i_rd_en    (s_acc),
        .i_rd_addr  (r_col),
        .i_pix      (i_s_axis_tdata),
        .i_top_we   (lane_ctl.shift),
        .i_top_addr (r_s1_idx),
        .i_top_data (rd_mid),
        .o_rd_top   (rd_top),
        .o_rd_mid   (rd_mid)
    );

    // One filter lane per color channel.
    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        rcv3_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (lane_ctl),
            .i_kernel (kernel),
            .i_top    (rd_top[ch*PW +: PW]),
            .i_mid    (rd_mid[ch*PW +: PW]),
            .i_pix    (r_s1_pix[ch*PW +: PW]),
            .o_result (lane_res[ch])
        );
    end

    // Merge the three channel results into one output transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_v4) begin
            r_out_data <= lane_res;
            r_out_last <= r_s4_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

/* rtl/rcv3_line_buf.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcv3_line_buf: two line memories for the 3x3 window
// The middle line takes each incoming pixel while its old entry is read out.
// The top line takes that old entry one stage later.
// ----------------------------------------------------------------------------
module rcv3_line_buf #(
    parameter int DEPTH = rcv3_pkg::MAX_WIDTH_DFLT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]       i_rd_addr,
    input  wire logic [rcv3_pkg::RGB_W-1:0]     i_pix,
    input  wire logic                           i_top_we,
    input  wire logic [$clog2(DEPTH)-1:0]       i_top_addr,
    input  wire logic [rcv3_pkg::RGB_W-1:0]     i_top_data,
    output logic      [rcv3_pkg::RGB_W-1:0]     o_rd_top,
    output logic      [rcv3_pkg::RGB_W-1:0]     o_rd_mid
);

    logic [rcv3_pkg::RGB_W-1:0] r_mem_top [DEPTH];
    logic [rcv3_pkg::RGB_W-1:0] r_mem_mid [DEPTH];
    logic [rcv3_pkg::RGB_W-1:0] r_rd_top;
    logic [rcv3_pkg::RGB_W-1:0] r_rd_mid;

    // Line one above: read the old entry and replace it with the new pixel.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_mid            <= r_mem_mid[i_rd_addr];
            r_mem_mid[i_rd_addr] <= i_pix;
        end
    end

    // Line two above: read on transfer, write back the retired middle entry.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_top <= r_mem_top[i_rd_addr];
        end
        if (i_top_we) begin
            r_mem_top[i_top_addr] <= i_top_data;
        end
    end

    assign o_rd_top = r_rd_top;
    assign o_rd_mid = r_rd_mid;

endmodule
`default_nettype wire

/* rtl/rcv3_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcv3_lane: one color channel of the 3x3 filter
// Keeps the channel's window, multiplies all nine taps in parallel, sums
// rows and then the whole window, and truncates and saturates to 0..255.
// ----------------------------------------------------------------------------
module rcv3_lane (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire rcv3_pkg::t_lane_ctl            i_ctl,
    input  wire rcv3_pkg::t_kernel              i_kernel,
    input  wire logic [rcv3_pkg::PIX_W-1:0]     i_top,
    input  wire logic [rcv3_pkg::PIX_W-1:0]     i_mid,
    input  wire logic [rcv3_pkg::PIX_W-1:0]     i_pix,
    output logic      [rcv3_pkg::PIX_W-1:0]     o_result
);

    localparam int PW = rcv3_pkg::PIX_W;
    localparam int AW = $bits(rcv3_pkg::t_acc);

    logic [rcv3_pkg::TAPS-1:0][PW-1:0] r_win;
    logic [rcv3_pkg::TAPS-1:0][PW-1:0] n_win;
    rcv3_pkg::t_prod                   r_prod [rcv3_pkg::TAPS];
    rcv3_pkg::t_prod                   n_prod [rcv3_pkg::TAPS];
    rcv3_pkg::t_rsum                   r_row  [3];
    rcv3_pkg::t_rsum                   n_row  [3];
    rcv3_pkg::t_acc                    n_acc;
    logic [PW-1:0]                     r_result;
    logic [PW-1:0]                     n_result;

    // Window shifts one column left; column 2 takes the new column.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]   = r_win[r*3+1];
            n_win[r*3+1] = r_win[r*3+2];
        end
        n_win[2] = i_top;
        n_win[5] = i_mid;
        n_win[8] = i_pix;
    end

    // Nine pixel-by-coefficient products on the shifted window.
    always_comb begin
        for (int k = 0; k < rcv3_pkg::TAPS; k++) begin
            n_prod[k] = $signed({1'b0, n_win[k]}) * $signed(i_kernel[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_ctl.shift) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int k = 0; k < rcv3_pkg::TAPS; k++) begin
                r_prod[k] <= n_prod[k];
            end
        end
    end

    // Row sums of three products each.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_row[r] = rcv3_pkg::t_rsum'(r_prod[r*3]) + rcv3_pkg::t_rsum'(r_prod[r*3+1])
                     + rcv3_pkg::t_rsum'(r_prod[r*3+2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_rows) begin
            for (int r = 0; r < 3; r++) begin
                r_row[r] <= n_row[r];
            end
        end
    end

    // Window total, fraction dropped, clamped to the pixel range.
    always_comb begin
        n_acc = rcv3_pkg::t_acc'(r_row[0]) + rcv3_pkg::t_acc'(r_row[1])
              + rcv3_pkg::t_acc'(r_row[2]);
        if (n_acc[AW-1]) begin
            n_result = '0;
        end else if (n_acc[AW-1:rcv3_pkg::FRAC_W] > (AW-rcv3_pkg::FRAC_W)'(255)) begin
            n_result = '1;
        end else begin
            n_result = n_acc[rcv3_pkg::FRAC_W+PW-1:rcv3_pkg::FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_all) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule
`default_nettype wire

/* rtl/rcv3_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcv3_checker: port-level checks of the RGB 3x3 convolution core
// Watches the stream handshakes and the flow control between the sides.
// ----------------------------------------------------------------------------
module rcv3_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_s_axis_tready,
    input wire logic                              o_m_axis_tvalid,
    input wire logic                              i_m_axis_tready,
    input wire logic [rcv3_pkg::RGB_W-1:0]        o_m_axis_tdata,
    input wire logic                              o_m_axis_tlast
);

    // A result offered but not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output valid dropped before transfer");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
        |=> $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output payload changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // With room at the output the whole pipeline moves, so input is taken.
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_axis_tvalid || i_m_axis_tready) |-> o_s_axis_tready)
        else $error("input stalled although output has room");

endmodule

bind rgb_conv2d_valid_3x3_core rcv3_checker u_checker (.*);
`default_nettype wire
